@@ sv/scps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock prescaler selection package
// Shared constants, the status and sequencer state types and the divider status struct.
// ----------------------------------------------------------------------------
package scps_pkg;

  // Number of serial controller instances that exist (1 to 4).
  localparam int NUM_PORTS = 2;

  // Field widths.
  localparam int CLK_W  = 32;   // frequencies in hertz
  localparam int DSR_W  = 40;   // divisor: a 32-bit target shifted by up to 6
  localparam int CNT_W  = 5;    // divider step counter, one quotient bit a step
  localparam int PORT_W = 2;
  localparam int SEC_W  = 4;
  localparam int CODE_W = 2;
  localparam int CTRL_W = 9;
  localparam int STAT_W = 2;

  localparam logic [SEC_W-1:0]  SEC_MAX    = 4'd8;
  localparam logic [SEC_W-1:0]  SEC_MIN    = 4'd1;
  localparam logic [CODE_W-1:0] CODE_START = 2'd3;   // primary divide by 1
  localparam logic [CODE_W-1:0] CODE_LAST  = 2'd0;   // primary divide by 64

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PORT  = 2'd1,
    ST_ZERO_TGT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC_START,
    S_SEC_WAIT,
    S_ACT_START,
    S_ACT_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/spi_clock_prescaler_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock prescaler selection
// Picks the primary and secondary serial clock dividers for a target rate.
// ----------------------------------------------------------------------------
// Each input beat carries a system clock, a target serial clock, a port number
// and the clock phase and polarity; each produces exactly one output beat with
// the primary divider code, the secondary divider, the resulting clock and the
// control word. The primary dividers 1, 4, 16 and 64 are tried in that order
// and the first one that leaves floor(sysclk / (target * primary)) at 8 or
// below is kept; if none does, divide by 64 is used with the secondary clamped
// to 8. A secondary of 0 is raised to 1. All division runs on one shared
// restoring divider that produces one quotient bit per cycle; each division
// is a start, 32 steps and a hand-back. A request needs one division per
// primary tried plus one for the actual frequency, passing through the idle
// and finish states on entry and exit. A bad port or a zero target is
// answered with an error status and all other fields zero; the port check
// comes first. The block takes one request at a time and is not ready while
// it works, but a finished result sits in the output register, so a new
// request is accepted while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module spi_clock_prescaler_select (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [scps_pkg::CLK_W-1:0]    system_clock,
  input  logic [scps_pkg::CLK_W-1:0]    target_frequency,
  input  logic [scps_pkg::PORT_W-1:0]   port_number,
  input  logic                          clock_phase,
  input  logic                          clock_polarity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scps_pkg::CODE_W-1:0]   primary_code,
  output logic [scps_pkg::SEC_W-1:0]    secondary_divider,
  output logic [scps_pkg::CLK_W-1:0]    actual_frequency,
  output logic [scps_pkg::CTRL_W-1:0]   control_word,
  output logic [scps_pkg::STAT_W-1:0]   status
);

  scps_pkg::state_t              state;
  scps_pkg::state_t              state_next;
  scps_pkg::status_t             stat;
  scps_pkg::div_stat_t           div_stat;

  // Request held for the whole computation.
  logic [scps_pkg::CLK_W-1:0]    sys;
  logic [scps_pkg::CLK_W-1:0]    tgt;
  logic                          phase;
  logic                          pol;

  // Working results.
  logic [scps_pkg::CODE_W-1:0]   code;
  logic [scps_pkg::SEC_W-1:0]    sec;
  logic [scps_pkg::CLK_W-1:0]    act;

  logic                          accept;
  logic                          bad_port;
  logic                          zero_tgt;
  logic                          fits;
  logic                          load_out;
  logic                          div_start;
  logic [scps_pkg::DSR_W-1:0]    div_divisor;
  logic [scps_pkg::CLK_W-1:0]    div_quotient;
  logic [scps_pkg::CODE_W:0]     pri_shift;
  logic [scps_pkg::SEC_W-1:0]    sec_gap;

  assign accept   = in_valid && in_ready;
  assign bad_port = ({1'b0, port_number} >= 3'(scps_pkg::NUM_PORTS));
  assign zero_tgt = (target_frequency == '0);

  // Primary divider 4^(3-code) is a left shift by twice (3-code).
  assign pri_shift = {scps_pkg::CODE_START - code, 1'b0};

  // A quotient of 8 or less fits; the upper bits must all be zero.
  assign fits = (div_quotient <= scps_pkg::CLK_W'(scps_pkg::SEC_MAX));

  assign sec_gap = scps_pkg::SEC_MAX - sec;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      scps_pkg::S_IDLE: begin
        if (accept) begin
          if (bad_port || zero_tgt) begin
            state_next = scps_pkg::S_FINISH;
          end else begin
            state_next = scps_pkg::S_SEC_START;
          end
        end
      end
      scps_pkg::S_SEC_START: begin
        state_next = scps_pkg::S_SEC_WAIT;
      end
      scps_pkg::S_SEC_WAIT: begin
        if (div_stat.done) begin
          if (fits || code == scps_pkg::CODE_LAST) begin
            state_next = scps_pkg::S_ACT_START;
          end else begin
            state_next = scps_pkg::S_SEC_START;
          end
        end
      end
      scps_pkg::S_ACT_START: begin
        state_next = scps_pkg::S_ACT_WAIT;
      end
      scps_pkg::S_ACT_WAIT: begin
        if (div_stat.done) begin
          state_next = scps_pkg::S_FINISH;
        end
      end
      scps_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = scps_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = scps_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    div_divisor = scps_pkg::DSR_W'(tgt) << pri_shift;
    unique case (state)
      scps_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      scps_pkg::S_SEC_START: begin
        div_start = 1'b1;
      end
      scps_pkg::S_ACT_START: begin
        div_start   = 1'b1;
        div_divisor = scps_pkg::DSR_W'(sec) << pri_shift;
      end
      scps_pkg::S_FINISH: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      sys   <= system_clock;
      tgt   <= target_frequency;
      phase <= clock_phase;
      pol   <= clock_polarity;
      sec   <= '0;
      act   <= '0;
      if (bad_port) begin
        stat <= scps_pkg::ST_BAD_PORT;
        code <= '0;
      end else if (zero_tgt) begin
        stat <= scps_pkg::ST_ZERO_TGT;
        code <= '0;
      end else begin
        stat <= scps_pkg::ST_OK;
        code <= scps_pkg::CODE_START;
      end
    end else if (state == scps_pkg::S_SEC_WAIT && div_stat.done) begin
      if (fits) begin
        sec <= (div_quotient == '0) ? scps_pkg::SEC_MIN
                                    : div_quotient[scps_pkg::SEC_W-1:0];
      end else if (code == scps_pkg::CODE_LAST) begin
        sec <= scps_pkg::SEC_MAX;
      end else begin
        code <= code - 1'b1;
      end
    end else if (state == scps_pkg::S_ACT_WAIT && div_stat.done) begin
      act <= div_quotient;
    end
  end

  // Output register: the result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      primary_code      <= code;
      secondary_divider <= sec;
      actual_frequency  <= act;
      status            <= stat;
      if (stat == scps_pkg::ST_OK) begin
        control_word <= {phase, 1'b0, pol, 1'b1, sec_gap[2:0], code};
      end else begin
        control_word <= '0;
      end
    end
  end

  scps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sys),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // A request holds the block until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while a request is still in progress");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == scps_pkg::S_SEC_WAIT || state == scps_pkg::S_ACT_WAIT))
    else $error("divider finished outside a wait state");

  // A good result always carries a secondary divider from 1 to 8.
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == scps_pkg::ST_OK) |->
      (secondary_divider >= scps_pkg::SEC_MIN && secondary_divider <= scps_pkg::SEC_MAX))
    else $error("secondary divider out of range on a good result");

  // An error result carries only its status.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != scps_pkg::ST_OK) |->
      (secondary_divider == '0 && actual_frequency == '0 &&
       control_word == '0 && primary_code == '0))
    else $error("error result carries nonzero fields");

endmodule

@@ sv/scps_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock prescaler selection: iterative divider
// Restoring unsigned divider, 32-bit dividend by 40-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module scps_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [scps_pkg::CLK_W-1:0]   dividend,
  input  logic [scps_pkg::DSR_W-1:0]   divisor,
  output logic [scps_pkg::CLK_W-1:0]   quotient,
  output scps_pkg::div_stat_t          stat
);

  logic                         busy;
  logic                         done;
  logic [scps_pkg::CNT_W-1:0]   cnt;
  logic [scps_pkg::DSR_W-1:0]   rem;
  logic [scps_pkg::DSR_W-1:0]   rem_next;
  logic [scps_pkg::DSR_W-1:0]   dsr;
  logic [scps_pkg::CLK_W-1:0]   dvd;
  logic [scps_pkg::DSR_W:0]     trial;
  logic [scps_pkg::DSR_W:0]     diff;
  logic                         ge;

  // The dividend register shifts left; quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem, dvd[scps_pkg::CLK_W-1]};
    diff     = trial - {1'b0, dsr};
    ge       = (trial >= {1'b0, dsr});
    rem_next = ge ? diff[scps_pkg::DSR_W-1:0] : trial[scps_pkg::DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == {scps_pkg::CNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[scps_pkg::CLK_W-2:0], ge};
    end
  end

  assign quotient  = dvd;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
